[hw/rtl/text_terminal_number_writer_macros.svh]
// Assertion macros shared by the text terminal writer RTL.
// No dependencies; included by the files that carry assertions.
`ifndef TEXT_TERMINAL_NUMBER_WRITER_MACROS_SVH
`define TEXT_TERMINAL_NUMBER_WRITER_MACROS_SVH

// Condition holds at every clock edge out of reset
`define TTNW_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("ttnw: invariant violated");

// Antecedent implies consequent in the same cycle
`define TTNW_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ttnw: same-cycle implication violated");

// Antecedent implies consequent in the next cycle
`define TTNW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ttnw: next-cycle implication violated");

`endif

[hw/rtl/ttnw_pkg.sv]
// Package for the text terminal writer: screen geometry, codes and the
// controller/datapath command and status types. No dependencies.
package ttnw_pkg;

  // Screen geometry
  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int COL_W       = $clog2(COLUMNS);
  localparam int ROW_W       = $clog2(ROWS);

  // Results per item are capped
  localparam int MAX_RESULTS = 35;
  localparam int EMIT_W      = $clog2(MAX_RESULTS + 1);

  // Character steps of each print form
  localparam int DEC_DIGITS  = 10;
  localparam int HEX_DIGITS  = 8;
  localparam int BIN_DIGITS  = 32;
  localparam int PREFIX_LEN  = 2;   // "0x" / "0b"
  localparam int MSG_LEN     = 20;  // "Invalid print format"
  localparam int STEP_W      = 6;

  // Configuration port
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;
  localparam logic [APB_ADDR_W-3:0] REG_TEXT_COLOR = '0;

  localparam logic [7:0] COLOR_DEFAULT = 8'h0F;
  localparam logic [7:0] CHAR_NEWLINE  = 8'd10;

  // Result kinds
  localparam logic KIND_CHAR  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    OP_PLACE = 2'd0,
    OP_PRINT = 2'd1,
    OP_RESET = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    FMT_DEC = 2'd0,
    FMT_HEX = 2'd1,
    FMT_BIN = 2'd2,
    FMT_BAD = 2'd3
  } fmt_t;

  // Controller to datapath
  typedef struct packed {
    logic load;  // capture the accepted word
    logic step;  // run one character step
    logic home;  // home cursor and emit a clear
  } ttnw_cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  op;        // operation of the captured word
    logic last;      // current step is the final one
    logic wrap;      // current step runs past the last row
    logic out_free;  // output register can take a word
  } ttnw_sts_t;

  // Powers of ten for decimal digit count
  function automatic logic [31:0] pow10(input logic [3:0] k);
    logic [31:0] p;
    case (k)
      4'd0:    p = 32'd1;
      4'd1:    p = 32'd10;
      4'd2:    p = 32'd100;
      4'd3:    p = 32'd1000;
      4'd4:    p = 32'd10000;
      4'd5:    p = 32'd100000;
      4'd6:    p = 32'd1000000;
      4'd7:    p = 32'd10000000;
      4'd8:    p = 32'd100000000;
      4'd9:    p = 32'd1000000000;
      default: p = 32'hFFFF_FFFF;
    endcase
    return p;
  endfunction

endpackage

[hw/rtl/ttnw_channels.sv]
// Valid/ready channel interfaces of the text terminal writer: the item
// channel and the cell result channel. No dependencies.
interface ttnw_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [7:0]         character;
  logic signed [31:0] number;
  logic [1:0]         format;

  modport source (output valid, operation, character, number, format, input ready);
  modport sink (input valid, operation, character, number, format, output ready);
endinterface

interface ttnw_cell_if;
  logic valid;
  logic ready;
  logic cell_kind;

  modport source (output valid, cell_kind, input ready);
  modport sink (input valid, cell_kind, output ready);
endinterface

[hw/rtl/text_terminal_number_writer.sv]
// Text terminal writer, top level: APB text color register, controller and
// datapath. Depends on ttnw_pkg, ttnw_channels, ttnw_ctrl, ttnw_datapath.
//
// Usage: words arrive on items (valid/ready): place a character, print a
// 32-bit signed number (decimal, hex, binary or the invalid-format message),
// or reset the terminal. Each result word on cells carries cell_kind: 0 for
// a character cell written at the cursor, 1 for a screen clear.
// items.ready is high only while the block is idle. After an accept, the
// controller decodes the word in its START state, then runs one character
// step per cycle while the output register can take a word.
// An item runs N character steps, plus a screen clear on each wrap past
// the last row: N is 1 for a character, 11 for decimal, 10 for hex, 34 for
// binary, 20 for the message; a terminal reset runs no step, only a clear.
// The step counter of the digit scanner sets N. At most 35 results per
// item are sent; the cursor still advances for the rest.
// A single output register holds the pending word; while that word waits
// on cells.ready the controller holds its step. Reset (rst, synchronous)
// homes the cursor, empties the output register and sets text_color to 0x0F.
module text_terminal_number_writer (
  input  logic                                clk,
  input  logic                                rst,
  ttnw_item_if.sink                           items,
  ttnw_cell_if.source                         cells,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ttnw_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [ttnw_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [ttnw_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import ttnw_pkg::*;

  ttnw_cmd_t  cmd;
  ttnw_sts_t  sts;
  logic       in_ready;
  logic [7:0] text_color;
  logic       reg_hit;

  assign items.ready = in_ready;

  ttnw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ttnw_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .operation (items.operation),
    .character (items.character),
    .number    (items.number),
    .format    (items.format),
    .cells     (cells)
  );

  // Configuration register; a terminal home restores the default color
  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_TEXT_COLOR);
  assign prdata  = reg_hit ? APB_DATA_W'(text_color) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= COLOR_DEFAULT;
    end else begin
      if (cmd.home) text_color <= COLOR_DEFAULT;
      if (psel && penable && pwrite && reg_hit) text_color <= pwdata[7:0];
    end
  end

endmodule

[hw/rtl/ttnw_ctrl.sv]
// Controller of the text terminal writer: sequences load, character steps
// and clears. Depends on ttnw_pkg.
module ttnw_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ttnw_pkg::ttnw_sts_t sts,
  output ttnw_pkg::ttnw_cmd_t cmd
);
  import ttnw_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_RUN,
    S_CLEAR
  } state_t;

  state_t state;
  logic   resume;  // go back to stepping after a clear

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = (state == S_IDLE);
    case (state)
      S_IDLE:  cmd.load = in_valid;
      S_RUN:   cmd.step = sts.out_free;
      S_CLEAR: cmd.home = sts.out_free;
      default: cmd = '0;
    endcase
  end

  // State
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      resume <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_START;
        end
        S_START: begin
          if (sts.op == OP_PLACE || sts.op == OP_PRINT) begin
            state <= S_RUN;
          end else if (sts.op == OP_RESET) begin
            resume <= 1'b0;
            state  <= S_CLEAR;
          end else begin
            state <= S_IDLE;
          end
        end
        S_RUN: begin
          if (sts.out_free) begin
            if (sts.wrap) begin
              resume <= !sts.last;
              state  <= S_CLEAR;
            end else if (sts.last) begin
              state <= S_IDLE;
            end
          end
        end
        S_CLEAR: begin
          if (sts.out_free) state <= resume ? S_RUN : S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/ttnw_datapath.sv]
// Datapath of the text terminal writer: captured word, digit scanner,
// cursor, result cap and output register. Depends on ttnw_pkg, ttnw_channels
// and the assertion macro header.
`include "text_terminal_number_writer_macros.svh"

module ttnw_datapath (
  input  logic                clk,
  input  logic                rst,
  input  ttnw_pkg::ttnw_cmd_t cmd,
  output ttnw_pkg::ttnw_sts_t sts,
  input  logic [1:0]          operation,
  input  logic [7:0]          character,
  input  logic signed [31:0]  number,
  input  logic [1:0]          format,
  ttnw_cell_if.source         cells
);
  import ttnw_pkg::*;

  // Captured word
  op_t               op;
  fmt_t              fmt;
  logic [7:0]        ch;
  logic              neg;
  logic [31:0]       mag;
  logic [31:0]       scan;
  logic              seen;
  logic [STEP_W-1:0] cnt;

  // Cursor and output
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [EMIT_W-1:0] emitted;
  logic              out_valid;
  logic              out_kind;

  logic              place;
  logic              newline;
  logic              digit_step;
  logic              last;
  logic              col_end;
  logic              row_end;
  logic              out_free;
  logic              can_emit;
  logic [STEP_W-1:0] load_cnt;

  assign last     = (cnt == '0);
  assign col_end  = (col == COL_W'(COLUMNS - 1));
  assign row_end  = (row == ROW_W'(ROWS - 1));
  assign out_free = !out_valid || cells.ready;
  assign can_emit = (emitted < EMIT_W'(MAX_RESULTS));

  // Step count of the incoming word, counted down to zero
  always_comb begin
    load_cnt = '0;
    if (op_t'(operation) == OP_PRINT) begin
      case (fmt_t'(format))
        FMT_DEC: load_cnt = STEP_W'(DEC_DIGITS);
        FMT_HEX: load_cnt = STEP_W'(HEX_DIGITS + PREFIX_LEN - 1);
        FMT_BIN: load_cnt = STEP_W'(BIN_DIGITS + PREFIX_LEN - 1);
        default: load_cnt = STEP_W'(MSG_LEN - 1);
      endcase
    end
  end

  // What the current step does
  always_comb begin
    place      = 1'b0;
    newline    = 1'b0;
    digit_step = 1'b0;
    if (op == OP_PLACE) begin
      newline = (ch == CHAR_NEWLINE);
      place   = !newline;
    end else begin
      case (fmt)
        FMT_DEC: begin
          // sign step first, then one step per decimal position
          if (cnt == STEP_W'(DEC_DIGITS)) place = neg;
          else place = (mag >= pow10(cnt[3:0])) || last;
        end
        FMT_HEX: begin
          digit_step = (cnt < STEP_W'(HEX_DIGITS));
          place      = !digit_step || (scan[31:28] != 4'd0) || seen || last;
        end
        FMT_BIN: begin
          digit_step = (cnt < STEP_W'(BIN_DIGITS));
          place      = !digit_step || scan[31] || seen || last;
        end
        default: place = 1'b1;
      endcase
    end
  end

  // Status
  always_comb begin
    sts.op       = op;
    sts.last     = last;
    sts.wrap     = (place && col_end && row_end) || (newline && row_end);
    sts.out_free = out_free;
  end

  // Captured word and digit scanner
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= op_t'(operation);
      fmt  <= fmt_t'(format);
      ch   <= character;
      neg  <= number[31];
      mag  <= number[31] ? (32'd0 - $unsigned(number)) : $unsigned(number);
      scan <= $unsigned(number);
      seen <= 1'b0;
      cnt  <= load_cnt;
    end else if (cmd.step) begin
      if (!last) cnt <= cnt - STEP_W'(1);
      if (digit_step) begin
        seen <= seen | place;
        if (fmt == FMT_HEX) scan <= {scan[27:0], 4'd0};
        else scan <= {scan[30:0], 1'b0};
      end
    end
  end

  // Cursor, result cap and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      emitted   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cells.ready) out_valid <= 1'b0;
      if (cmd.load) emitted <= '0;
      if (cmd.step && (place || newline)) begin
        if (place && !col_end) begin
          col <= col + COL_W'(1);
        end else begin
          col <= '0;
          row <= row_end ? '0 : row + ROW_W'(1);
        end
      end
      if (cmd.home) begin
        col <= '0;
        row <= '0;
      end
      if (((cmd.step && place) || cmd.home) && can_emit) begin
        out_valid <= 1'b1;
        out_kind  <= cmd.home ? KIND_CLEAR : KIND_CHAR;
        emitted   <= emitted + EMIT_W'(1);
      end
    end
  end

  assign cells.valid     = out_valid;
  assign cells.cell_kind = out_kind;

  `TTNW_ASSERT_ALWAYS(a_cursor_range, clk, rst,
    (col <= COL_W'(COLUMNS - 1)) && (row <= ROW_W'(ROWS - 1)))
  `TTNW_ASSERT_ALWAYS(a_emit_cap, clk, rst, emitted <= EMIT_W'(MAX_RESULTS))
  `TTNW_ASSERT_IMPL(a_no_overwrite, clk, rst, cmd.step || cmd.home, out_free)
  `TTNW_ASSERT_NEXT(a_home_cursor, clk, rst, cmd.home, (col == '0) && (row == '0))

endmodule

[test/ttnw_cell_checker.sv]
// Checker for the text terminal writer: models the cursor and the text color
// from accepted item and APB words and checks every cell word in order.
// Depends on ttnw_pkg and the channel interfaces in ttnw_channels.
module ttnw_cell_checker (
  input  logic                            clk,
  input  logic                            rst,
  ttnw_item_if                            items,
  ttnw_cell_if                            cells,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ttnw_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ttnw_pkg::APB_DATA_W-1:0] pwdata,
  input  logic                            pready,
  output int                              mismatches,
  output int                              cells_pending
);
  import ttnw_pkg::*;

  // Model state: cursor, color and the cell kinds still owed by the block
  int         cursor_col;
  int         cursor_row;
  logic [7:0] text_color;
  int         cells_this_word;
  int         errors_seen;
  logic       cells_due[$];
  logic       want_kind;

  // Queue one cell word; words past the per-item cap are dropped
  task automatic push_cell(input logic kind);
    if (cells_this_word < MAX_RESULTS) begin
      cells_due.push_back(kind);
      cells_this_word++;
    end
  endtask

  task automatic home_cursor();
    cursor_col = 0;
    cursor_row = 0;
    text_color = COLOR_DEFAULT;
    push_cell(KIND_CLEAR);
  endtask

  task automatic next_row();
    cursor_col = 0;
    cursor_row++;
    if (cursor_row >= ROWS) home_cursor();
  endtask

  task automatic place_char(input logic [7:0] ch);
    if (ch == CHAR_NEWLINE) begin
      next_row();
    end else begin
      push_cell(KIND_CHAR);
      cursor_col++;
      if (cursor_col >= COLUMNS) next_row();
    end
  endtask

  // Number as text: decimal, 0x hex, 0b binary or the bad-format message
  task automatic print_value(input logic [31:0] bits, input fmt_t fmt);
    string       msg;
    logic [31:0] mag;
    logic [3:0]  digs[10];
    logic [3:0]  nib;
    int          n;
    logic        seen;
    msg  = "Invalid print format";
    n    = 0;
    seen = 1'b0;
    case (fmt)
      FMT_DEC: begin
        if (bits == 32'd0) begin
          place_char("0");
        end else begin
          mag = bits;
          if (bits[31]) begin
            place_char("-");
            mag = 32'd0 - bits;  // unsigned, so the most negative value keeps its size
          end
          while (mag != 32'd0) begin
            digs[n] = 4'(mag % 32'd10);
            n++;
            mag = mag / 10;
          end
          for (int i = n - 1; i >= 0; i--) place_char("0" + digs[i]);
        end
      end
      FMT_HEX: begin
        place_char("0");
        place_char("x");
        for (int i = 28; i >= 0; i -= 4) begin
          nib = bits[i +: 4];
          if (nib != 4'd0 || seen || i == 0) begin
            seen = 1'b1;
            place_char(nib < 4'd10 ? "0" + nib : "A" + nib - 8'd10);
          end
        end
      end
      FMT_BIN: begin
        place_char("0");
        place_char("b");
        for (int i = 31; i >= 0; i--) begin
          if (bits[i] || seen || i == 0) begin
            seen = 1'b1;
            place_char(bits[i] ? "1" : "0");
          end
        end
      end
      default: begin
        for (int i = 0; i < msg.len(); i++) place_char(msg[i]);
      end
    endcase
  endtask

  task automatic predict_cells(input op_t op, input logic [7:0] ch,
                               input logic [31:0] num, input fmt_t fmt);
    cells_this_word = 0;
    case (op)
      OP_PLACE: place_char(ch);
      OP_PRINT: print_value(num, fmt);
      OP_RESET: home_cursor();
      default: ;  // unused operation, nothing happens
    endcase
  endtask

  // Track APB writes, predict on item words, compare on cell words
  always @(posedge clk) begin
    if (rst) begin
      cursor_col  = 0;
      cursor_row  = 0;
      text_color  = COLOR_DEFAULT;
      errors_seen = 0;
      cells_due.delete();
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr[APB_ADDR_W-1:2] == REG_TEXT_COLOR) begin
        text_color = pwdata[7:0];
      end
      if (items.valid && items.ready) begin
        predict_cells(op_t'(items.operation), items.character, items.number,
                      fmt_t'(items.format));
      end
      if (cells.valid && cells.ready) begin
        if (cells_due.size() == 0) begin
          $error("cell_kind: expected no word, actual %0b", cells.cell_kind);
          errors_seen++;
        end else begin
          want_kind = cells_due.pop_front();
          if (cells.cell_kind !== want_kind) begin
            $error("cell_kind: expected %0b, actual %0b", want_kind, cells.cell_kind);
            errors_seen++;
          end
        end
      end
    end
    mismatches    <= errors_seen;
    cells_pending <= cells_due.size();
  end

endmodule

[test/text_terminal_number_writer_tb.sv]
// Testbench top for the text terminal writer: clock, reset, item and APB
// stimulus with sender bursts and receiver stalls, watchdog and verdict.
// Depends on ttnw_pkg, ttnw_channels, the block and ttnw_cell_checker.
module text_terminal_number_writer_tb;
  import ttnw_pkg::*;

  localparam int IDLE_LIMIT    = 1000;
  localparam int SETTLE_CYCLES = 48;
  localparam int WORDS_PER_RUN = 100;
  localparam int RUNS          = 4;

  // Receiver stall styles
  localparam int RX_ALWAYS   = 0;
  localparam int RX_PERIODIC = 1;
  localparam int RX_RANDOM   = 2;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  int                    mismatches;
  int                    cells_pending;
  int                    stall_mode;
  int                    stall_count;
  int                    idle_cycles;
  int                    burst_left;
  bit                    gaps_on;

  ttnw_item_if items_ch();
  ttnw_cell_if cells_ch();

  text_terminal_number_writer DUT (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .cells   (cells_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ttnw_cell_checker cell_check (
    .clk           (clk),
    .rst           (rst),
    .items         (items_ch),
    .cells         (cells_ch),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .mismatches    (mismatches),
    .cells_pending (cells_pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: ready pattern picked per run
  initial begin
    cells_ch.ready <= 1'b1;
    stall_count    <= 0;
    forever begin
      @(posedge clk);
      stall_count <= stall_count + 1;
      case (stall_mode)
        RX_ALWAYS:   cells_ch.ready <= 1'b1;
        RX_PERIODIC: cells_ch.ready <= (stall_count % 5) > 1;
        default:     cells_ch.ready <= $urandom_range(0, 9) > 2;
      endcase
    end
  end

  // Watchdog: too long without any accepted word or APB access
  always @(posedge clk) begin
    if ((items_ch.valid && items_ch.ready) || (cells_ch.valid && cells_ch.ready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic write_text_color(input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_TEXT_COLOR, 2'b00};
    pwdata  <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Hold off until every owed cell word is in, then let the block go idle
  task automatic wait_until_drained();
    @(posedge clk);
    while (cells_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Offer one item word, then maybe open a gap at the end of a burst
  task automatic send_word(input op_t op, input logic [7:0] ch,
                           input logic [31:0] num, input fmt_t fmt);
    items_ch.valid     <= 1'b1;
    items_ch.operation <= op;
    items_ch.character <= ch;
    items_ch.number    <= num;
    items_ch.format    <= fmt;
    @(posedge clk);
    while (!items_ch.ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 16);
      if (gaps_on) begin
        items_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  // Random item: mostly characters and prints, newlines often enough to wrap
  task automatic random_word(output op_t op, output logic [7:0] ch,
                             output logic [31:0] num, output fmt_t fmt);
    int pick;
    pick = $urandom_range(0, 99);
    ch   = 8'($urandom_range(0, 255));
    num  = $urandom;
    fmt  = fmt_t'(2'($urandom_range(0, 3)));
    if (pick < 50) begin
      op = OP_PLACE;
      if ($urandom_range(0, 3) == 0) ch = CHAR_NEWLINE;
    end else if (pick < 92) begin
      op = OP_PRINT;
      if ($urandom_range(0, 9) == 0) fmt = FMT_BAD;
      else fmt = fmt_t'(2'($urandom_range(0, 2)));
      case ($urandom_range(0, 3))
        0: num = $urandom_range(0, 40) - 20;
        1: num = $urandom >> $urandom_range(0, 31);
        2: begin
          case ($urandom_range(0, 3))
            0: num = 32'd0;
            1: num = 32'hFFFF_FFFF;
            2: num = 32'h8000_0000;
            default: num = 32'h7FFF_FFFF;
          endcase
        end
        default: ;
      endcase
    end else if (pick < 96) begin
      op = OP_RESET;
    end else begin
      op = OP_NONE;
    end
  endtask

  initial begin
    op_t         op;
    logic [7:0]  ch;
    logic [31:0] num;
    fmt_t        fmt;
    logic [7:0]  run_colors[RUNS];

    run_colors = '{8'h00, 8'hFF, 8'h00, 8'h0F};
    run_colors[2] = 8'($urandom_range(1, 254));
    rst                <= 1'b1;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    items_ch.valid     <= 1'b0;
    items_ch.operation <= OP_NONE;
    items_ch.character <= 8'd0;
    items_ch.number    <= 32'sd0;
    items_ch.format    <= FMT_DEC;
    stall_mode         <= RX_RANDOM;
    burst_left         = 4;
    gaps_on            = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_text_color(8'h3C);

    // Directed: field extremes, every operation and format, edge numbers
    send_word(OP_PLACE, "A", 32'd0, FMT_DEC);
    send_word(OP_PLACE, 8'h00, 32'd0, FMT_DEC);
    send_word(OP_PLACE, 8'hFF, 32'hFFFF_FFFF, FMT_BAD);
    send_word(OP_PLACE, CHAR_NEWLINE, 32'd0, FMT_DEC);
    send_word(OP_PRINT, 8'h00, 32'd0, FMT_DEC);
    send_word(OP_PRINT, 8'h00, 32'h8000_0000, FMT_DEC);
    send_word(OP_PRINT, 8'h00, 32'h7FFF_FFFF, FMT_DEC);
    send_word(OP_PRINT, 8'h00, 32'hFFFF_FFFF, FMT_DEC);
    send_word(OP_PRINT, 8'h00, 32'h1234_5678, FMT_DEC);
    send_word(OP_PRINT, 8'h00, 32'd0, FMT_HEX);
    send_word(OP_PRINT, 8'h00, 32'hFFFF_FFFF, FMT_HEX);
    send_word(OP_PRINT, 8'h00, 32'h0000_00A0, FMT_HEX);
    send_word(OP_PRINT, 8'h00, 32'd0, FMT_BIN);
    send_word(OP_PRINT, 8'h00, 32'hFFFF_FFFF, FMT_BIN);
    send_word(OP_PRINT, 8'h00, 32'h8000_0000, FMT_BIN);
    send_word(OP_PRINT, 8'h00, 32'd5, FMT_BIN);
    send_word(OP_PRINT, 8'h00, 32'd123, FMT_BAD);
    send_word(OP_NONE, 8'hAA, 32'h5555_5555, FMT_BIN);
    send_word(OP_PLACE, CHAR_NEWLINE, 32'd0, FMT_DEC);
    send_word(OP_RESET, 8'h55, 32'hAAAA_AAAA, FMT_HEX);
    send_word(OP_PRINT, 8'h00, 32'hFFFF_FFFF, FMT_BAD);

    // Random runs, each with its own color; stall style follows run % 3 and run 1 sends without gaps
    for (int run = 0; run < RUNS; run++) begin
      items_ch.valid <= 1'b0;
      wait_until_drained();
      write_text_color(run_colors[run]);
      stall_mode <= run % 3;
      gaps_on    = (run != 1);
      repeat (WORDS_PER_RUN) begin
        random_word(op, ch, num, fmt);
        send_word(op, ch, num, fmt);
      end
    end

    items_ch.valid <= 1'b0;
    wait_until_drained();
    if (mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
